// ===== hw/rtl/positional_insert_delete_array_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Positional insert/delete array unit: assertion macros
// Clocked, reset-qualified property checks used by the checker file.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_UNIT_MACROS_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_UNIT_MACROS_SVH

// Check a property at every rising edge outside reset.
`define PIDA_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Check that a signal holds while its channel is stalled.
`define PIDA_ASSERT_HOLD(name, clk, rst_n, vld, rdy, sig, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) \
		((vld) && !(rdy)) |=> $stable(sig)) \
		else $error(msg);

`endif

// ===== hw/rtl/pida_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional insert/delete array package
// Sizes, command and status codes, controller states and shared structs.
// ----------------------------------------------------------------------------
package pida_pkg;

	// List capacity and derived widths
	localparam int DEPTH    = 128;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CNT_W    = $clog2(DEPTH + 1);

	// Fixed field widths
	localparam int ACTION_W = 2;
	localparam int POS_W    = 8;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int ENTRY_W  = 8;

	// Width for comparing a position against the count
	localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

	typedef enum logic [ACTION_W-1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_READ   = 2'd2,
		ACT_CLEAR  = 2'd3
	} pida_action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} pida_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT_UP,
		S_WRITE_ITEM,
		S_SHIFT_DN,
		S_READ_WAIT,
		S_RESULT
	} pida_state_t;

	// Memory access request from the controller
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [VAL_W-1:0]  wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} pida_mem_req_t;

	// Finished result item
	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic signed [VAL_W-1:0] read_value;
		logic [ENTRY_W-1:0]     entry_count;
	} pida_res_t;

endpackage

// ===== hw/rtl/pida_if.sv =====
// ----------------------------------------------------------------------------
// Positional insert/delete array channels
// Valid/ready command and response channels with their payload fields.
// ----------------------------------------------------------------------------
interface pida_cmd_if
	import pida_pkg::*;
	;
	logic                    valid;
	logic                    ready;
	logic [ACTION_W-1:0]     action;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] item_value;

	modport source (output valid, output action, output position, output item_value,
		input ready);
	modport sink (input valid, input action, input position, input item_value,
		output ready);
endinterface

interface pida_rsp_if
	import pida_pkg::*;
	;
	logic                    valid;
	logic                    ready;
	logic [STATUS_W-1:0]     status;
	logic signed [VAL_W-1:0] read_value;
	logic [ENTRY_W-1:0]      entry_count;

	modport source (output valid, output status, output read_value, output entry_count,
		input ready);
	modport sink (input valid, input status, input read_value, input entry_count,
		output ready);
endinterface

// ===== hw/rtl/positional_insert_delete_array_unit.sv =====
// ----------------------------------------------------------------------------
// Positional insert/delete array unit
// Dense list of signed 32-bit entries with insert, delete, read and clear.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one item per command: action (insert, delete, read, clear),
//   a zero-based position and, for insert, the value. rsp returns exactly one
//   item per command: status, the read value (zero unless a read succeeds)
//   and the entry count after the command.
//   Commands run one at a time. An insert moves each entry from the end
//   down to the position up by one, then writes the value at the position;
//   a delete moves each entry above the position down by one; a read waits
//   for the registered RAM read; clear and rejected commands go straight
//   to the result. The next command is taken once the result has moved
//   into the output register. The tail walk through the entry RAM moves
//   one entry per cycle over its single read and single write port.
//   A stalled rsp holds its item in the output register; the next command is
//   still taken and waits in the final state until the register frees up.
//   Reset empties the list at once; the entry RAM is not cleared and only
//   entries below the count are ever returned by a read.
// ----------------------------------------------------------------------------
module positional_insert_delete_array_unit
	import pida_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	pida_cmd_if.sink   cmd,
	pida_rsp_if.source rsp
);

	pida_mem_req_t    mem_req;
	logic [VAL_W-1:0] mem_rdata;
	logic             res_valid;
	logic             res_ready;
	pida_res_t        res;
	logic             rsp_valid_q;
	pida_res_t        rsp_q;

	// Command decode and tail walk
	pida_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// Entry storage
	pida_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (VAL_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// Output register: load when empty or draining
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.read_value  = rsp_q.read_value;
	assign rsp.entry_count = rsp_q.entry_count;

endmodule

// ===== hw/rtl/pida_ram.sv =====
// ----------------------------------------------------------------------------
// Positional insert/delete array RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pida_ram #(
	parameter int ADDR_W = 7,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/pida_ctrl.sv =====
// ----------------------------------------------------------------------------
// Positional insert/delete array controller
// Decodes commands, walks the tail through the RAM one entry per cycle and
// keeps the fill count.
// ----------------------------------------------------------------------------
module pida_ctrl
	import pida_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	pida_cmd_if.sink          cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output pida_res_t         res,
	output pida_mem_req_t     mem_req,
	input  logic [VAL_W-1:0]  mem_rdata
);

	pida_state_t             state_q, state_d;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        pos_q;
	logic [CNT_W-1:0]        idx_q;
	logic [VAL_W-1:0]        item_q;
	pida_status_t            status_q;
	logic [VAL_W-1:0]        rdval_q;
	logic                    wr_vld_s1;
	logic [ADDR_W-1:0]       wr_addr_s1;

	logic                    accept;
	pida_action_t            act;
	logic [CMP_W-1:0]        pos_ext;
	logic [CMP_W-1:0]        cnt_ext;
	logic                    pos_gt_cnt;
	logic                    pos_ge_cnt;
	logic                    full;
	logic [CNT_W-1:0]        idx_m1;
	logic [CNT_W-1:0]        pos_p1;
	logic                    up_done;
	logic                    dn_done;

	// Decode the command and compare it against the count
	assign accept     = cmd.valid && cmd.ready;
	assign act        = pida_action_t'(cmd.action);
	assign pos_ext    = CMP_W'(cmd.position);
	assign cnt_ext    = CMP_W'(cnt_q);
	assign pos_gt_cnt = pos_ext > cnt_ext;
	assign pos_ge_cnt = pos_ext >= cnt_ext;
	assign full       = cnt_q == CNT_W'(DEPTH);
	assign pos_p1     = pos_ext[CNT_W-1:0] + CNT_W'(1);
	assign idx_m1     = idx_q - CNT_W'(1);
	assign up_done    = idx_q == pos_q;
	assign dn_done    = idx_q == cnt_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					case (act)
						ACT_INSERT: state_d = (pos_gt_cnt || full) ? S_RESULT : S_SHIFT_UP;
						ACT_DELETE: state_d = pos_ge_cnt ? S_RESULT : S_SHIFT_DN;
						ACT_READ:   state_d = pos_ge_cnt ? S_RESULT : S_READ_WAIT;
						default:    state_d = S_RESULT;
					endcase
				end
			end
			S_SHIFT_UP: begin
				if (up_done) begin
					state_d = S_WRITE_ITEM;
				end
			end
			S_WRITE_ITEM: state_d = S_RESULT;
			S_SHIFT_DN: begin
				if (dn_done) begin
					state_d = S_RESULT;
				end
			end
			S_READ_WAIT: state_d = S_RESULT;
			S_RESULT: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs: handshake and RAM requests
	always_comb begin
		cmd.ready     = 1'b0;
		res_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = wr_addr_s1;
		mem_req.wdata = mem_rdata;
		mem_req.re    = 1'b0;
		mem_req.raddr = idx_q[ADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				cmd.ready     = 1'b1;
				mem_req.re    = cmd.valid && (act == ACT_READ);
				mem_req.raddr = cmd.position[ADDR_W-1:0];
			end
			S_SHIFT_UP: begin
				mem_req.we    = wr_vld_s1;
				mem_req.re    = !up_done;
				mem_req.raddr = idx_m1[ADDR_W-1:0];
			end
			S_WRITE_ITEM: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = pos_q[ADDR_W-1:0];
				mem_req.wdata = item_q;
			end
			S_SHIFT_DN: begin
				mem_req.we    = wr_vld_s1;
				mem_req.re    = !dn_done;
			end
			S_RESULT: res_valid = 1'b1;
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			wr_vld_s1 <= mem_req.re && (state_q != S_IDLE);
			if (accept && act == ACT_CLEAR) begin
				cnt_q <= '0;
			end else if (state_q == S_WRITE_ITEM) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (state_q == S_SHIFT_DN && dn_done) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// Payload registers: command copy, walk index and result fields
	always_ff @(posedge clk) begin
		wr_addr_s1 <= (state_q == S_SHIFT_UP) ? idx_q[ADDR_W-1:0] : idx_m1[ADDR_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					pos_q    <= pos_ext[CNT_W-1:0];
					item_q   <= cmd.item_value;
					idx_q    <= (act == ACT_INSERT) ? cnt_q : pos_p1;
					rdval_q  <= '0;
					case (act)
						ACT_INSERT: begin
							if (pos_gt_cnt) begin
								status_q <= ST_RANGE;
							end else if (full) begin
								status_q <= ST_FULL;
							end else begin
								status_q <= ST_OK;
							end
						end
						ACT_DELETE, ACT_READ: begin
							if (pos_ge_cnt) begin
								status_q <= ST_RANGE;
							end else begin
								status_q <= ST_OK;
							end
						end
						default: status_q <= ST_OK;
					endcase
				end
			end
			S_SHIFT_UP: begin
				if (!up_done) begin
					idx_q <= idx_m1;
				end
			end
			S_SHIFT_DN: begin
				if (!dn_done) begin
					idx_q <= idx_q + CNT_W'(1);
				end
			end
			S_READ_WAIT: rdval_q <= mem_rdata;
			default: ;
		endcase
	end

	// Result item
	always_comb begin
		logic [CMP_W-1:0] cnt_w;
		cnt_w           = CMP_W'(cnt_q);
		res.status      = status_q;
		res.read_value  = rdval_q;
		res.entry_count = cnt_w[ENTRY_W-1:0];
	end

endmodule

// ===== hw/rtl/pida_checker.sv =====
// ----------------------------------------------------------------------------
// Positional insert/delete array checker
// Port-level checks on the command and response channels, bound to the top.
// ----------------------------------------------------------------------------
`include "positional_insert_delete_array_unit_macros.svh"

module pida_checker
	import pida_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic [VAL_W-1:0]    rsp_read_value,
	input logic [ENTRY_W-1:0]  rsp_entry_count
);

	// One command in flight: ready drops right after an item is taken
	`PIDA_ASSERT(a_one_in_flight, clk, arst_n, (cmd_valid && cmd_ready) |=> !cmd_ready, "ready stayed high after command")
	// A full-list reject only happens at capacity
	`PIDA_ASSERT(a_full_at_depth, clk, arst_n, (rsp_valid && rsp_status == ST_FULL) |-> (rsp_entry_count == ENTRY_W'(DEPTH)), "full status below capacity")
	// A nonzero read value only comes with an ok status
	`PIDA_ASSERT(a_value_ok, clk, arst_n, (rsp_valid && rsp_read_value != '0) |-> (rsp_status == ST_OK), "read value on failed command")
	// Stalled response holds its entry count
	`PIDA_ASSERT_HOLD(a_rsp_hold, clk, arst_n, rsp_valid, rsp_ready, rsp_entry_count, "response changed while stalled")

endmodule

bind positional_insert_delete_array_unit pida_checker u_pida_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.cmd_valid       (cmd.valid),
	.cmd_ready       (cmd.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_read_value  (rsp.read_value),
	.rsp_entry_count (rsp.entry_count)
);
